/* hw/rtl/suv_pkg.sv */
// shared constants, types and angle table for the spherical texel address unit
package suv_pkg;

   // datapath width of the cordic vectors (q16.16 offset with 16 guard bits and growth)
   localparam int CORD_W = 54;
   // angle width, units of 2^-32 turn
   localparam int ANG_W = 32;
   // largest number of cordic iterations the angle table covers
   localparam int MAX_ITER = 24;

   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
   // cordic gain limit in q30
   localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

   // configuration register indexes
   localparam logic [1:0] CSR_TEX_WIDTH = 2'd0;
   localparam logic [1:0] CSR_TEX_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ROW_STRIDE = 2'd2;
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd3;

   // configuration values seen by the address stages
   typedef struct packed {
      logic [12:0] tex_width;
      logic [12:0] tex_height;
      logic [14:0] row_stride_bytes;
      logic [2:0]  bytes_per_pixel;
   } cfg_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic [ANG_W-1:0] atan_turn(input int idx);
      logic [ANG_W-1:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/suv_cordic.sv */
// pipelined cordic vectoring unit: an entry fold stage, then one iteration per register stage
module suv_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [suv_pkg::CORD_W-1:0]    in_x,
   input  logic signed [suv_pkg::CORD_W-1:0]    in_y,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [suv_pkg::CORD_W-1:0]    out_mag,
   output logic [suv_pkg::ANG_W-1:0]            out_angle,
   output logic [SIDE_W-1:0]                    out_side
);

   logic signed [suv_pkg::CORD_W-1:0] x_ff [STAGES+1];
   logic signed [suv_pkg::CORD_W-1:0] y_ff [STAGES+1];
   logic [suv_pkg::ANG_W-1:0]         z_ff [STAGES+1];
   logic [SIDE_W-1:0]                 side_ff [STAGES+1];
   logic signed [suv_pkg::CORD_W-1:0] x_in [STAGES+1];
   logic signed [suv_pkg::CORD_W-1:0] y_in [STAGES+1];
   logic [suv_pkg::ANG_W-1:0]         z_in [STAGES+1];
   logic [STAGES:0]                   valid_ff;
   logic [STAGES+1:0]                 load;

   // a stage loads when empty or when the next one moves
   assign load[STAGES+1] = out_ready;
   genvar k;
   generate
      for (k = 0; k <= STAGES; k++) begin : g_load
         assign load[k] = !valid_ff[k] || load[k+1];
      end
   endgenerate

   // entry: fold a vector in the left half plane by a half turn
   always_comb begin
      if (in_x < 0) begin
         x_in[0] = -in_x;
         y_in[0] = -in_y;
         z_in[0] = suv_pkg::HALF_TURN;
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
   end

   // micro-rotations toward the x axis
   generate
      for (k = 1; k <= STAGES; k++) begin : g_iter
         logic signed [suv_pkg::CORD_W-1:0] sx;
         logic signed [suv_pkg::CORD_W-1:0] sy;
         logic                              y_neg;
         assign sx    = x_ff[k-1] >>> (k-1);
         assign sy    = y_ff[k-1] >>> (k-1);
         assign y_neg = y_ff[k-1][suv_pkg::CORD_W-1];
         assign x_in[k] = y_neg ? x_ff[k-1] - sy : x_ff[k-1] + sy;
         assign y_in[k] = y_neg ? y_ff[k-1] + sx : y_ff[k-1] - sx;
         assign z_in[k] = y_neg ? z_ff[k-1] - suv_pkg::atan_turn(k-1)
                                : z_ff[k-1] + suv_pkg::atan_turn(k-1);
      end
   endgenerate

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         for (int s = 1; s <= STAGES; s++) begin
            if (load[s]) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load[0]) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         z_ff[0]    <= z_in[0];
         side_ff[0] <= in_side;
      end
      for (int s = 1; s <= STAGES; s++) begin
         if (load[s]) begin
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
            z_ff[s]    <= z_in[s];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[STAGES];
   assign out_mag   = x_ff[STAGES];
   assign out_angle = z_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

/* hw/rtl/suv_texel.sv */
// angle to fraction, texel index and byte offset stages
module suv_texel #(
   parameter int MAX_TEX_DIM = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [suv_pkg::ANG_W-1:0]    phi,
   input  logic [suv_pkg::ANG_W-1:0]    theta,
   input  logic                         degen,
   input  suv_pkg::cfg_type             cfg,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [87:0]                  out_data
);

   logic [2:0]  valid_ff;
   logic [3:0]  load;
   logic [31:0] theta_c;
   logic [15:0] u_in;
   logic [15:0] v_in;
   logic [12:0] w_sat;
   logic [12:0] h_sat;
   logic [28:0] col_prod;
   logic [28:0] row_prod;
   logic [15:0] u1_ff, v1_ff, u2_ff, v2_ff, u3_ff, v3_ff;
   logic [11:0] col1_ff, row1_ff, col2_ff, row2_ff, col3_ff, row3_ff;
   logic        dg1_ff, dg2_ff, dg3_ff;
   logic [26:0] row_off_ff;
   logic [17:0] col_off_ff;
   logic [25:0] off_ff;

   assign load[3] = out_ready;
   assign load[2] = !valid_ff[2] || load[3];
   assign load[1] = !valid_ff[1] || load[2];
   assign load[0] = !valid_ff[0] || load[1];

   // clamp theta into [0, half turn], form fractions and texel indexes
   always_comb begin
      if (theta >= suv_pkg::THREE_QUARTER_TURN) begin
         theta_c = '0;
      end else if (theta > suv_pkg::HALF_TURN) begin
         theta_c = suv_pkg::HALF_TURN;
      end else begin
         theta_c = theta;
      end
      u_in  = 16'((phi + suv_pkg::HALF_TURN) >> 16);
      v_in  = theta_c[30:15];
      w_sat = (33'(cfg.tex_width) > 33'(MAX_TEX_DIM)) ? 13'(MAX_TEX_DIM) : cfg.tex_width;
      h_sat = (33'(cfg.tex_height) > 33'(MAX_TEX_DIM)) ? 13'(MAX_TEX_DIM) : cfg.tex_height;
      col_prod = 29'(u_in) * 29'(w_sat);
      row_prod = 29'(v_in) * 29'(h_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) valid_ff[0] <= in_valid;
         if (load[1]) valid_ff[1] <= valid_ff[0];
         if (load[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // index stage, then offset products, then the sum
   always_ff @(posedge clock) begin
      if (load[0]) begin
         u1_ff   <= u_in;
         v1_ff   <= v_in;
         col1_ff <= col_prod[27:16];
         row1_ff <= row_prod[27:16];
         dg1_ff  <= degen;
      end
      if (load[1]) begin
         u2_ff      <= u1_ff;
         v2_ff      <= v1_ff;
         col2_ff    <= col1_ff;
         row2_ff    <= row1_ff;
         dg2_ff     <= dg1_ff;
         row_off_ff <= 27'(row1_ff) * 27'(cfg.row_stride_bytes);
         col_off_ff <= 18'(col1_ff) * 18'(cfg.bytes_per_pixel);
      end
      if (load[2]) begin
         u3_ff   <= dg2_ff ? '0 : u2_ff;
         v3_ff   <= dg2_ff ? '0 : v2_ff;
         col3_ff <= dg2_ff ? '0 : col2_ff;
         row3_ff <= dg2_ff ? '0 : row2_ff;
         dg3_ff  <= dg2_ff;
         off_ff  <= dg2_ff ? '0 : 26'(row_off_ff + 27'(col_off_ff));
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[2];
   assign out_data  = {5'b0, dg3_ff, off_ff, row3_ff, col3_ff, v3_ff, u3_ff};

endmodule

/* hw/rtl/sphere_uv_texel_address_unit.sv */
// top level: spherical uv mapping and texel byte address, fully pipelined
// throughput: one transfer per cycle while rsp is not stalled; each cordic iteration has its own register stage
// a stalled rsp side lets items fill empty stages before req is held off
// reset (synchronous, active high) empties the pipeline and loads register defaults:
// width 1, height 1, stride 4, bytes per pixel 4
module sphere_uv_texel_address_unit #(
   parameter int CORDIC_STAGES = 16,
   parameter int MAX_TEX_DIM   = 4096
) (
   input  logic         clock,
   input  logic         reset,
   // hit_x, hit_y, hit_z, center_x, center_y, center_z, 32 bits each from bit 0
   input  logic [191:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // u_frac 16, v_frac 16, texel_col 12, texel_row 12, byte_offset 26, degenerate 1, pad
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_wdata
);

   localparam int NIT = (CORDIC_STAGES > suv_pkg::MAX_ITER) ? suv_pkg::MAX_ITER : CORDIC_STAGES;
   localparam int W   = suv_pkg::CORD_W;
   localparam int S1W = W + 2;
   localparam int S2W = suv_pkg::ANG_W + 1;

   suv_pkg::cfg_type cfg_ff;

   logic [2:0]          fvalid_ff;
   logic [3:0]          fload;
   logic signed [32:0]  px_ff, py_ff, pz_ff;
   logic                dg1_ff, dg2_ff, dg3_ff, xz2_ff, xz3_ff;
   logic [63:0]         prod_ff;
   logic                neg_ff;
   logic signed [W-1:0] gx2_ff, gz2_ff, gx3_ff, gz3_ff, kpy_ff;
   logic [32:0]         py_mag;
   logic signed [W-1:0] kpy_mag;

   logic                c1_ready, c1_valid, c2_ready, c2_valid, t_ready;
   logic signed [W-1:0] c1_mag, c2_mag;
   logic [31:0]         c1_ang, c2_ang;
   logic [S1W-1:0]      c1_side;
   logic [S2W-1:0]      c2_side;
   logic signed [W-1:0] kpy_c, kr_c;
   logic                xz_c;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width        <= 13'd1;
         cfg_ff.tex_height       <= 13'd1;
         cfg_ff.row_stride_bytes <= 15'd4;
         cfg_ff.bytes_per_pixel  <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            suv_pkg::CSR_TEX_WIDTH:       cfg_ff.tex_width        <= csr_wdata[12:0];
            suv_pkg::CSR_TEX_HEIGHT:      cfg_ff.tex_height       <= csr_wdata[12:0];
            suv_pkg::CSR_ROW_STRIDE:      cfg_ff.row_stride_bytes <= csr_wdata;
            suv_pkg::CSR_BYTES_PER_PIXEL: cfg_ff.bytes_per_pixel  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // front stages: offset, gain product, signed k*py
   assign fload[3] = c1_ready;
   assign fload[2] = !fvalid_ff[2] || fload[3];
   assign fload[1] = !fvalid_ff[1] || fload[2];
   assign fload[0] = !fvalid_ff[0] || fload[1];

   assign py_mag  = py_ff[32] ? 33'(-py_ff) : 33'(py_ff);
   assign kpy_mag = W'(prod_ff >> 14);

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
      end else begin
         if (fload[0]) fvalid_ff[0] <= req_tvalid;
         if (fload[1]) fvalid_ff[1] <= fvalid_ff[0];
         if (fload[2]) fvalid_ff[2] <= fvalid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (fload[0]) begin
         px_ff  <= $signed({req_tdata[31], req_tdata[31:0]})
                 - $signed({req_tdata[127], req_tdata[127:96]});
         py_ff  <= $signed({req_tdata[63], req_tdata[63:32]})
                 - $signed({req_tdata[159], req_tdata[159:128]});
         pz_ff  <= $signed({req_tdata[95], req_tdata[95:64]})
                 - $signed({req_tdata[191], req_tdata[191:160]});
         dg1_ff <= (req_tdata[31:0] == req_tdata[127:96])
                && (req_tdata[63:32] == req_tdata[159:128])
                && (req_tdata[95:64] == req_tdata[191:160]);
      end
      if (fload[1]) begin
         prod_ff <= 64'(py_mag) * 64'(suv_pkg::GAIN_Q30);
         neg_ff  <= py_ff[32];
         gx2_ff  <= W'($signed({px_ff, 16'b0}));
         gz2_ff  <= W'($signed({pz_ff, 16'b0}));
         xz2_ff  <= (px_ff == '0) && (pz_ff == '0);
         dg2_ff  <= dg1_ff;
      end
      if (fload[2]) begin
         kpy_ff <= neg_ff ? -kpy_mag : kpy_mag;
         gx3_ff <= gx2_ff;
         gz3_ff <= gz2_ff;
         xz3_ff <= xz2_ff;
         dg3_ff <= dg2_ff;
      end
   end

   assign req_tready = fload[0];

   // longitude and radius in the xz plane
   suv_cordic #(.STAGES(NIT), .SIDE_W(S1W)) u_cordic_xz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fvalid_ff[2]),
      .in_ready  (c1_ready),
      .in_x      (gx3_ff),
      .in_y      (gz3_ff),
      .in_side   ({kpy_ff, xz3_ff, dg3_ff}),
      .out_valid (c1_valid),
      .out_ready (c2_ready),
      .out_mag   (c1_mag),
      .out_angle (c1_ang),
      .out_side  (c1_side)
   );

   // on the y axis the longitude and radius are zero
   assign kpy_c = c1_side[S1W-1:2];
   assign xz_c  = c1_side[1];
   assign kr_c  = xz_c ? '0 : c1_mag;

   // colatitude from (k*py, k*r)
   suv_cordic #(.STAGES(NIT), .SIDE_W(S2W)) u_cordic_lat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_ready  (c2_ready),
      .in_x      (kpy_c),
      .in_y      (kr_c),
      .in_side   ({(xz_c ? 32'd0 : c1_ang), c1_side[0]}),
      .out_valid (c2_valid),
      .out_ready (t_ready),
      .out_mag   (c2_mag),
      .out_angle (c2_ang),
      .out_side  (c2_side)
   );

   suv_texel #(.MAX_TEX_DIM(MAX_TEX_DIM)) u_texel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid && (c2_mag == c2_mag)),
      .in_ready  (t_ready),
      .phi       (c2_side[S2W-1:1]),
      .theta     (c2_ang),
      .degen     (c2_side[0]),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

/* hw/rtl/suv_checker.sv */
// port-level checks for the spherical texel address unit
module suv_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [87:0]  rsp_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // a degenerate result carries zeros in every other field
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[82]) |-> (rsp_tdata[81:0] == '0))
      else $error("degenerate result with nonzero fields");

   // a pending result is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp valid dropped while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // nothing comes out in the cycle after reset without any request
   assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !$past(req_tvalid && req_tready)) |-> !rsp_tvalid)
      else $error("result out of an empty pipeline");

endmodule

bind sphere_uv_texel_address_unit suv_checker u_suv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

/* tb/sv/tb_sphere_uv_texel_address_unit.sv */
// self-checking testbench for the spherical uv texel address unit
`timescale 1ns / 100ps

module tb_sphere_uv_texel_address_unit;

   localparam int STAGES = 16;
   localparam int TEX_DIM_MAX = 4096;
   localparam int DRAIN_CYCLES = 2 * STAGES + 8 + 20;
   localparam longint CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic        degenerate;
      logic [25:0] byte_offset;
      logic [11:0] texel_row;
      logic [11:0] texel_col;
      logic [15:0] v_frac;
      logic [15:0] u_frac;
   } texel_rsp_type;

   logic         clock = 0;
   logic         reset = 1;
   logic [191:0] req_tdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [87:0]  rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic         csr_we = 0;
   logic [1:0]   csr_index = suv_pkg::CSR_TEX_WIDTH;
   logic [14:0]  csr_wdata = '0;

   // shadow copy of the configuration registers
   logic [12:0] sh_width = 13'd1;
   logic [12:0] sh_height = 13'd1;
   logic [14:0] sh_stride = 15'd4;
   logic [2:0]  sh_bpp = 3'd4;

   texel_rsp_type expected_texels[$];
   int  mismatches = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  recv_hold = 0;
   longint cycles = 0;

   sphere_uv_texel_address_unit #(.CORDIC_STAGES(STAGES), .MAX_TEX_DIM(TEX_DIM_MAX)) dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[sphere_uv_texel_address_unit] ERROR");
         $finish;
      end
   end

   // arithmetic shift right on 64-bit signed values
   function automatic longint shr_arith(longint val, int sh);
      return val >>> sh;
   endfunction

   // vectoring rotation: angle in 2^-32 turn, magnitude scaled by the gain
   function automatic logic [31:0] vector_angle(longint xin, longint yin, output longint mag);
      longint x, y, nx, ny;
      logic [31:0] z;
      x = xin;
      y = yin;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = suv_pkg::HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr_arith(y, i);
            ny = y - shr_arith(x, i);
            z = z + atan_turn_tb(i);
         end else begin
            nx = x - shr_arith(y, i);
            ny = y + shr_arith(x, i);
            z = z - atan_turn_tb(i);
         end
         x = nx;
         y = ny;
      end
      mag = x;
      return z;
   endfunction

   // arctangent table, 2^-32 turn units
   function automatic logic [31:0] atan_turn_tb(int i);
      logic [31:0] tbl [0:23];
      tbl = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
              32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
              32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
              32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
      return tbl[i];
   endfunction

   // fraction to texel index with size saturation and wrap
   function automatic logic [11:0] frac_to_texel(logic [15:0] frac, logic [12:0] size_in);
      longint unsigned sz;
      sz = size_in;
      if (sz == 0) return '0;
      if (sz > TEX_DIM_MAX) sz = TEX_DIM_MAX;
      return 12'((((longint'(frac)) * sz) >> 16) % sz);
   endfunction

   // expected texel address for one hit point
   function automatic texel_rsp_type predict_texel(logic [191:0] d);
      texel_rsp_type r;
      longint px, py, pz, kr, unused_mag, kpy;
      longint unsigned m;
      logic [31:0] phi, theta;
      logic [15:0] uf, vf;
      logic [11:0] col, row;
      longint unsigned off;
      px = longint'($signed(d[31:0])) - longint'($signed(d[127:96]));
      py = longint'($signed(d[63:32])) - longint'($signed(d[159:128]));
      pz = longint'($signed(d[95:64])) - longint'($signed(d[191:160]));
      r = '0;
      if (px == 0 && py == 0 && pz == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      px = px * 65536;
      pz = pz * 65536;
      phi = '0;
      kr = 0;
      if (px != 0 || pz != 0) phi = vector_angle(px, pz, kr);
      m = (py < 0) ? longint'(-py) : longint'(py);
      kpy = longint'((m * 64'(suv_pkg::GAIN_Q30)) >> 14);
      if (py < 0) kpy = -kpy;
      theta = vector_angle(kpy, kr, unused_mag);
      if (theta >= suv_pkg::THREE_QUARTER_TURN) theta = '0;
      else if (theta > suv_pkg::HALF_TURN) theta = suv_pkg::HALF_TURN;
      uf = 16'((phi + suv_pkg::HALF_TURN) >> 16);
      vf = 16'(theta >> 15);
      col = frac_to_texel(uf, sh_width);
      row = frac_to_texel(vf, sh_height);
      off = longint'(row) * sh_stride + longint'(col) * sh_bpp;
      r.u_frac = uf;
      r.v_frac = vf;
      r.texel_col = col;
      r.texel_row = row;
      r.byte_offset = off[25:0];
      return r;
   endfunction

   // receiver: random stalls plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      texel_rsp_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = texel_rsp_type'(rsp_tdata[82:0]);
         if (expected_texels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            exp_r = expected_texels.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp u %h v %h col %0d row %0d off %0d deg %b | got u %h v %h col %0d row %0d off %0d deg %b",
                     exp_r.u_frac, exp_r.v_frac, exp_r.texel_col, exp_r.texel_row,
                     exp_r.byte_offset, exp_r.degenerate, got.u_frac, got.v_frac,
                     got.texel_col, got.texel_row, got.byte_offset, got.degenerate);
            end
         end
      end
   end

   // offer one hit point and record its expected texel on transfer
   task automatic send_hit(logic [191:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tdata <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_texels.push_back(predict_texel(d));
   endtask

   task automatic send_point(logic [31:0] hx, hy, hz, cx, cy, cz);
      send_hit({cz, cy, cx, hz, hy, hx});
   endtask

   // let all outstanding results drain
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [14:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         suv_pkg::CSR_TEX_WIDTH:  sh_width = val[12:0];
         suv_pkg::CSR_TEX_HEIGHT: sh_height = val[12:0];
         suv_pkg::CSR_ROW_STRIDE: sh_stride = val[14:0];
         default:                 sh_bpp = val[2:0];
      endcase
   endtask

   task automatic set_texture(logic [14:0] w, h, s, b);
      wait_drained();
      write_reg(suv_pkg::CSR_TEX_WIDTH, w);
      write_reg(suv_pkg::CSR_TEX_HEIGHT, h);
      write_reg(suv_pkg::CSR_ROW_STRIDE, s);
      write_reg(suv_pkg::CSR_BYTES_PER_PIXEL, b);
      @(posedge clock);
   endtask

   // random hit point: mostly near a random centre, some full range and axis cases
   task automatic send_random_hit();
      logic [31:0] c[3], h[3];
      int kind;
      kind = $urandom_range(99);
      for (int i = 0; i < 3; i++) c[i] = $urandom;
      for (int i = 0; i < 3; i++) begin
         if (kind < 25) h[i] = $urandom;
         else if (kind < 85) h[i] = c[i] + ($urandom_range(1, 20) == 1 ? 32'd0
                                  : $signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff);
         else if (kind < 95) h[i] = (i == (kind % 3)) ? $urandom : c[i];
         else h[i] = c[i];
      end
      send_point(h[0], h[1], h[2], c[0], c[1], c[2]);
   endtask

   // directed corners: zero offset, axes, half-turn wrap and field extremes
   task automatic test_directed();
      set_texture(15'd4096, 15'd4096, 15'd16384, 15'd4);
      send_point(0, 0, 0, 0, 0, 0);
      send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 32'h12345678, 32'h9abcdef0,
                 32'h0f0f0f0f);
      send_point(0, 32'h00010000, 0, 0, 0, 0);
      send_point(0, 32'hffff0000, 0, 0, 0, 0);
      send_point(32'hffff0000, 0, 0, 0, 0, 0);
      send_point(32'h00010000, 0, 0, 0, 0, 0);
      send_point(0, 0, 32'h00010000, 0, 0, 0);
      send_point(0, 0, 32'hffff0000, 0, 0, 0);
      send_point(32'hffffffff, 0, 0, 0, 0, 0);
      send_point(32'h80000000, 0, 0, 0, 0, 0);
      send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000);
      send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff);
      send_point(32'h7fffffff, 32'h80000000, 32'h00000001, 32'h80000000, 32'h7fffffff,
                 32'hffffffff);
      send_point(0, 32'h7fffffff, 32'h00000001, 0, 32'h80000000, 0);
      send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
      send_point(32'h00000001, 32'h00000001, 32'h00000001, 0, 0, 0);
      // zero sizes and oversized registers
      set_texture(15'd0, 15'd8191, 15'd0, 15'd0);
      send_point(32'h00010000, 32'h00020000, 32'hfffe0000, 0, 0, 0);
      send_point(32'hffff0000, 32'hffff0000, 32'h00010000, 0, 0, 0);
      set_texture(15'd8191, 15'd0, 15'h7fff, 15'd7);
      send_point(32'h00010000, 32'h00020000, 32'hfffe0000, 0, 0, 0);
      send_point(32'h7fffffff, 32'h7fffffff, 32'h00000000, 32'h80000000, 0, 0);
   endtask

   task automatic test_random(int n, int s_pct, int r_pct);
      logic [14:0] w, h, s, b;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int ph = 0; ph < 3; ph++) begin
         w = $urandom_range(1, 20) == 1 ? 15'($urandom_range(0, 8191))
                                        : 15'($urandom_range(1, 4096));
         h = $urandom_range(1, 20) == 1 ? 15'($urandom_range(0, 8191))
                                        : 15'($urandom_range(1, 4096));
         s = 15'($urandom);
         b = 15'($urandom_range(0, 7));
         if (ph == 0) begin
            w = 15'd1; h = 15'd1; s = 15'd1; b = 15'd1;
         end
         set_texture(w, h, s, b);
         for (int i = 0; i < n / 3; i++) send_random_hit();
      end
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      set_texture(15'd640, 15'd480, 15'd2560, 15'd4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 300;
      for (int i = 0; i < 150; i++) send_random_hit();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(570, 30, 62);
      test_random(570, 62, 30);
      test_random(420, 0, 0);
      test_backpressure();
      wait_drained();
      if (mismatches == 0 && expected_texels.size() == 0) begin
         $display("[sphere_uv_texel_address_unit] OK");
      end else begin
         $display("[sphere_uv_texel_address_unit] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/suv_pkg.sv
hw/rtl/suv_cordic.sv
hw/rtl/suv_texel.sv
hw/rtl/sphere_uv_texel_address_unit.sv
hw/rtl/suv_checker.sv
tb/sv/tb_sphere_uv_texel_address_unit.sv
